// ===== hw/rtl/trpe_pkg.sv =====
// Shared types and constants for the touch report to pointer events block.
package trpe_pkg;

  localparam int RAW_BITS  = 16;
  localparam int SIZE_BITS = 13;
  localparam int PROD_BITS = RAW_BITS + SIZE_BITS;

  localparam logic [7:0] HDR_A = 8'h20;
  localparam logic [7:0] HDR_B = 8'h21;

  localparam logic [1:0] EV_MOVE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic [2:0] CFG_X_MIN  = 3'd0;
  localparam logic [2:0] CFG_X_SPAN = 3'd1;
  localparam logic [2:0] CFG_Y_MIN  = 3'd2;
  localparam logic [2:0] CFG_Y_SPAN = 3'd3;
  localparam logic [2:0] CFG_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_HEIGHT = 3'd5;

  localparam logic [2:0] POS_HEADER = 3'd0;
  localparam logic [2:0] POS_X_LOW  = 3'd1;
  localparam logic [2:0] POS_X_HIGH = 3'd2;
  localparam logic [2:0] POS_Y_LOW  = 3'd3;
  localparam logic [2:0] POS_Y_HIGH = 3'd4;

  typedef enum logic [1:0] {
    AX_IDLE,
    AX_MUL,
    AX_DIV,
    AX_DONE
  } axis_state_t;

endpackage

// ===== hw/rtl/trpe_axis.sv =====
// Bit-serial scaling of one raw coordinate: shift-add multiply, restoring divide, clamp.
module trpe_axis import trpe_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RAW_BITS-1:0]   raw,
  input  logic [RAW_BITS-1:0]   mn,
  input  logic [RAW_BITS-1:0]   span,
  input  logic [SIZE_BITS-1:0]  size,
  output logic                  done,
  output logic [COORD_BITS-1:0] coord
);

  localparam logic [4:0] MUL_LAST = 5'(SIZE_BITS - 1);
  localparam logic [4:0] DIV_LAST = 5'(PROD_BITS - 1);
  localparam logic [PROD_BITS-1:0] CMAX = PROD_BITS'((64'd1 << COORD_BITS) - 64'd1);

  axis_state_t state, state_next;
  logic [4:0] count;
  logic [PROD_BITS-1:0] acc;
  logic [RAW_BITS-1:0] rem;
  logic [RAW_BITS-1:0] divisor;
  logic [RAW_BITS-1:0] diff;
  logic [SIZE_BITS-1:0] size_q;
  logic below;
  logic [RAW_BITS:0] mul_sum;
  logic [RAW_BITS:0] shifted;
  logic [RAW_BITS:0] trial;
  logic [PROD_BITS-1:0] lim;
  logic [PROD_BITS-1:0] quot;

  assign mul_sum = {1'b0, acc[PROD_BITS-1:SIZE_BITS]} + (acc[0] ? {1'b0, diff} : '0);
  assign shifted = {rem, acc[PROD_BITS-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      AX_IDLE: begin
        if (start) begin
          below   <= raw < mn;
          diff    <= raw - mn;
          divisor <= (span == '0) ? RAW_BITS'(1) : span;
          size_q  <= size;
          acc     <= {{RAW_BITS{1'b0}}, size};
          count   <= '0;
        end
      end
      AX_MUL: begin
        acc <= {mul_sum, acc[SIZE_BITS-1:1]};
        if (count == MUL_LAST) begin
          count <= '0;
          rem   <= '0;
        end else begin
          count <= count + 5'd1;
        end
      end
      AX_DIV: begin
        acc   <= {acc[PROD_BITS-2:0], ~trial[RAW_BITS]};
        rem   <= trial[RAW_BITS] ? shifted[RAW_BITS-1:0] : trial[RAW_BITS-1:0];
        count <= count + 5'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      AX_IDLE: begin
        if (start) begin
          state_next = AX_MUL;
        end
      end
      AX_MUL: begin
        if (count == MUL_LAST) begin
          state_next = AX_DIV;
        end
      end
      AX_DIV: begin
        if (count == DIV_LAST) begin
          state_next = AX_DONE;
        end
      end
      AX_DONE: begin
        done       = 1'b1;
        state_next = AX_IDLE;
      end
      default: begin
        state_next = AX_IDLE;
      end
    endcase
  end

  always_comb begin
    lim = PROD_BITS'(size_q - SIZE_BITS'(1));
    if (lim > CMAX) begin
      lim = CMAX;
    end
    if (below) begin
      quot = '0;
    end else if (acc > lim) begin
      quot = lim;
    end else begin
      quot = acc;
    end
    coord = quot[COORD_BITS-1:0];
  end

endmodule

// ===== hw/rtl/touch_report_to_pointer_events.sv =====
// Top level: touch report byte parser, tick-based release detection and pointer output.
//
// Input transactions carry req_type and report_byte on in_valid/in_stall. A report is a
// header byte (0x20 or 0x21), then raw X and raw Y, each 16 bits little-endian. A bad
// header byte is dropped. A tick transaction (req_type 1) closes one timer period.
// Output transactions carry event_kind, pointer_x and pointer_y on out_valid/out_stall.
// Header and data bytes that complete no report do not raise in_stall. The byte that
// completes a report starts two bit-serial scaling units, one per axis, which run a
// shift-add multiply and a restoring divide; in_stall is held high until the press or
// move event appears. A tick that emits a release shows it on the output the cycle
// after it is taken.
// When the receiver stalls, the result holds in the output register, and no byte or tick
// is taken until that register has been emptied.
// The configuration port writes one register per cycle with cfg_write high and should be
// used only while no transaction is in progress. Reset restores the default calibration,
// clears the parser, the button state and the period flags, and empties the output.
module touch_report_to_pointer_events import trpe_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [7:0]            report_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            event_kind,
  output logic [COORD_BITS-1:0] pointer_x,
  output logic [COORD_BITS-1:0] pointer_y,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  logic [RAW_BITS-1:0]  raw_x_min;
  logic [RAW_BITS-1:0]  raw_x_span;
  logic [RAW_BITS-1:0]  raw_y_min;
  logic [RAW_BITS-1:0]  raw_y_span;
  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;

  logic [2:0]           byte_position;
  logic [RAW_BITS-1:0]  raw_x_acc;
  logic [7:0]           raw_y_low;
  logic                 button_down;
  logic                 report_this_period;
  logic                 report_last_period;
  logic                 busy;
  logic [1:0]           pending_kind;

  logic                 in_take;
  logic                 start;
  logic                 release_take;
  logic [RAW_BITS-1:0]  raw_y;
  logic                 x_done;
  logic                 y_done;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;

  assign in_stall     = busy | (out_valid & out_stall);
  assign in_take      = in_valid & ~in_stall;
  assign start        = in_take & ~req_type & (byte_position == POS_Y_HIGH);
  assign release_take = in_take & req_type & ~report_this_period & report_last_period;
  assign raw_y        = {report_byte, raw_y_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_x_min     <= RAW_BITS'(55);
      raw_x_span    <= RAW_BITS'(3848);
      raw_y_min     <= RAW_BITS'(234);
      raw_y_span    <= RAW_BITS'(3793);
      screen_width  <= SIZE_BITS'(1280);
      screen_height <= SIZE_BITS'(800);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_X_MIN:  raw_x_min     <= cfg_data;
        CFG_X_SPAN: raw_x_span    <= cfg_data;
        CFG_Y_MIN:  raw_y_min     <= cfg_data;
        CFG_Y_SPAN: raw_y_span    <= cfg_data;
        CFG_WIDTH:  screen_width  <= cfg_data[SIZE_BITS-1:0];
        CFG_HEIGHT: screen_height <= cfg_data[SIZE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= POS_HEADER;
      raw_x_acc          <= '0;
      raw_y_low          <= '0;
      button_down        <= 1'b0;
      report_this_period <= 1'b0;
      report_last_period <= 1'b0;
      busy               <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (x_done) begin
        busy       <= 1'b0;
        out_valid  <= 1'b1;
        event_kind <= pending_kind;
        pointer_x  <= x_coord;
        pointer_y  <= y_coord;
      end else if (release_take) begin
        out_valid  <= 1'b1;
        event_kind <= EV_RELEASE;
        pointer_x  <= '0;
        pointer_y  <= '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        if (req_type) begin
          if (!report_this_period && report_last_period) begin
            button_down <= 1'b0;
          end
          report_last_period <= report_this_period;
          report_this_period <= 1'b0;
        end else begin
          case (byte_position)
            POS_X_LOW: begin
              raw_x_acc     <= {8'h00, report_byte};
              byte_position <= POS_X_HIGH;
            end
            POS_X_HIGH: begin
              raw_x_acc     <= {report_byte, raw_x_acc[7:0]};
              byte_position <= POS_Y_LOW;
            end
            POS_Y_LOW: begin
              raw_y_low     <= report_byte;
              byte_position <= POS_Y_HIGH;
            end
            POS_Y_HIGH: begin
              byte_position      <= POS_HEADER;
              pending_kind       <= button_down ? EV_MOVE : EV_PRESS;
              button_down        <= 1'b1;
              report_this_period <= 1'b1;
              busy               <= 1'b1;
            end
            default: begin
              byte_position <= (report_byte == HDR_A || report_byte == HDR_B) ?
                               POS_X_LOW : POS_HEADER;
            end
          endcase
        end
      end
    end
  end

  trpe_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .raw   (raw_x_acc),
    .mn    (raw_x_min),
    .span  (raw_x_span),
    .size  (screen_width),
    .done  (x_done),
    .coord (x_coord)
  );

  trpe_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .raw   (raw_y),
    .mn    (raw_y_min),
    .span  (raw_y_span),
    .size  (screen_height),
    .done  (y_done),
    .coord (y_coord)
  );

  a_axes_in_step: assert property (@(posedge clk) disable iff (rst) x_done == y_done)
    else $error("Scaling units finished in different cycles.");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst) busy |-> in_stall)
    else $error("Input taken while a report is being scaled.");

  a_done_loads: assert property (@(posedge clk) disable iff (rst) x_done |=> out_valid)
    else $error("Finished scaling did not produce an output transaction.");

  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_RELEASE) |-> (pointer_x == '0 && pointer_y == '0))
    else $error("Release event carries a nonzero position.");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking directed and random testbench for the touch report to pointer events block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trpe_pkg::*;

  localparam int          CB           = 12;
  localparam int          IDLE_LIMIT   = 3000;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          PHASE_ITEMS  = 240;
  localparam int          PHASES       = 8;
  localparam logic [2:0]  CFG_SPARE_A  = 3'd6;
  localparam logic [2:0]  CFG_SPARE_B  = 3'd7;

  typedef struct packed {
    logic       req_type;
    logic [7:0] report_byte;
  } touch_req_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pointer_event_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          req_type = 1'b0;
  logic [7:0]    report_byte = 8'h00;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    event_kind;
  logic [CB-1:0] pointer_x;
  logic [CB-1:0] pointer_y;
  logic          cfg_write = 1'b0;
  logic [2:0]    cfg_index = CFG_X_MIN;
  logic [15:0]   cfg_data = 16'h0000;

  touch_req_t     queued_requests[$];
  pointer_event_t expected_events[$];
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             errors = 0;
  int             quiet_cycles = 0;

  logic [15:0] cal_x_min = 16'd55;
  logic [15:0] cal_x_span = 16'd3848;
  logic [15:0] cal_y_min = 16'd234;
  logic [15:0] cal_y_span = 16'd3793;
  logic [12:0] cal_width = 13'd1280;
  logic [12:0] cal_height = 13'd800;

  logic [2:0]  parse_pos = POS_HEADER;
  logic [15:0] x_raw_acc = 16'h0000;
  logic [7:0]  y_raw_low = 8'h00;
  logic        button_held = 1'b0;
  logic        touched_this_period = 1'b0;
  logic        touched_last_period = 1'b0;

  touch_report_to_pointer_events #(.COORD_BITS(CB)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .report_byte(report_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .pointer_x  (pointer_x),
    .pointer_y  (pointer_y),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [CB-1:0] scale_to_pixels(input logic [15:0] raw,
                                                    input logic [15:0] mn,
                                                    input logic [15:0] span,
                                                    input logic [12:0] size);
    longint unsigned q;
    longint unsigned lim;
    longint unsigned d;
    if (size == 0 || raw < mn) return '0;
    d = (span == 0) ? 1 : span;
    q = raw;
    q = (q - mn) * size / d;
    lim = size;
    lim = lim - 1;
    if (lim > (1 << CB) - 1) lim = (1 << CB) - 1;
    if (q > lim) q = lim;
    return q[CB-1:0];
  endfunction

  task automatic predict_pointer_event(input logic rt, input logic [7:0] b);
    pointer_event_t ev;
    logic [15:0] raw_y;
    if (rt) begin
      if (!touched_this_period && touched_last_period) begin
        ev.kind = EV_RELEASE;
        ev.x = '0;
        ev.y = '0;
        expected_events.push_back(ev);
        button_held = 1'b0;
      end
      touched_last_period = touched_this_period;
      touched_this_period = 1'b0;
    end else begin
      case (parse_pos)
        POS_X_LOW: begin
          x_raw_acc = {8'h00, b};
          parse_pos = POS_X_HIGH;
        end
        POS_X_HIGH: begin
          x_raw_acc = {b, x_raw_acc[7:0]};
          parse_pos = POS_Y_LOW;
        end
        POS_Y_LOW: begin
          y_raw_low = b;
          parse_pos = POS_Y_HIGH;
        end
        POS_Y_HIGH: begin
          raw_y = {b, y_raw_low};
          parse_pos = POS_HEADER;
          ev.kind = button_held ? EV_MOVE : EV_PRESS;
          ev.x = scale_to_pixels(x_raw_acc, cal_x_min, cal_x_span, cal_width);
          ev.y = scale_to_pixels(raw_y, cal_y_min, cal_y_span, cal_height);
          expected_events.push_back(ev);
          button_held = 1'b1;
          touched_this_period = 1'b1;
        end
        default: begin
          parse_pos = (b == HDR_A || b == HDR_B) ? POS_X_LOW : POS_HEADER;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    touch_req_t nxt_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_pointer_event(req_type, report_byte);
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_req = queued_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt_req.req_type;
          report_byte <= nxt_req.report_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pointer_event_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          if (errors < 10)
            $display("unexpected event: kind %0d x %0d y %0d", event_kind, pointer_x, pointer_y);
          errors++;
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind || pointer_x !== want.x || pointer_y !== want.y) begin
            if (errors < 10)
              $display("mismatch: expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
                       want.kind, want.x, want.y, event_kind, pointer_x, pointer_y);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    touch_req_t r;
    r.req_type = 1'b0;
    r.report_byte = b;
    queued_requests.push_back(r);
  endtask

  task automatic add_tick();
    touch_req_t r;
    r.req_type = 1'b1;
    r.report_byte = 8'($urandom);
    queued_requests.push_back(r);
  endtask

  task automatic add_report(input logic [7:0] hdr, input logic [15:0] rx,
                            input logic [15:0] ry);
    add_byte(hdr);
    add_byte(rx[7:0]);
    add_byte(rx[15:8]);
    add_byte(ry[7:0]);
    add_byte(ry[15:8]);
  endtask

  function automatic logic [15:0] pick_raw(input logic [15:0] mn, input logic [15:0] span);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return mn;
      3: return mn - 16'd1;
      4: return mn + span;
      5: return mn + span - 16'd1;
      6: return 16'($urandom);
      default: return mn + 16'($urandom_range(span));
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_X_MIN:  cal_x_min = val;
      CFG_X_SPAN: cal_x_span = val;
      CFG_Y_MIN:  cal_y_min = val;
      CFG_Y_SPAN: cal_y_span = val;
      CFG_WIDTH:  cal_width = val[12:0];
      CFG_HEIGHT: cal_height = val[12:0];
      default: ;
    endcase
  endtask

  task automatic write_calibration(input logic [15:0] xm, input logic [15:0] xs,
                                   input logic [15:0] ym, input logic [15:0] ys,
                                   input logic [15:0] w, input logic [15:0] h);
    write_reg(CFG_X_MIN, xm);
    write_reg(CFG_X_SPAN, xs);
    write_reg(CFG_Y_MIN, ym);
    write_reg(CFG_Y_SPAN, ys);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input int ph);
    case (ph)
      0: write_calibration(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd4096, 16'd4096);
      1: write_calibration(16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd1, 16'd1);
      2: begin
        write_calibration(16'd100, 16'd0, 16'd200, 16'd0, 16'hFFFF, 16'hE000 | 16'd4096);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'hFFFF);
      end
      3: write_calibration(16'd1000, 16'd2000, 16'd500, 16'd300, 16'd0, 16'd0);
      4, 5: write_calibration(16'($urandom_range(4000)), 16'($urandom_range(1, 65535)),
                              16'($urandom_range(4000)), 16'($urandom_range(1, 5000)),
                              16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
      6: write_calibration(16'd55, 16'd3848, 16'd234, 16'd3793, 16'd1280, 16'd800);
      default: write_calibration(16'($urandom_range(300)), 16'($urandom_range(1, 16)),
                                 16'($urandom_range(300)), 16'($urandom_range(1, 16)),
                                 16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_random_phase();
    int added;
    int sel;
    int n;
    added = 0;
    while (added < PHASE_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        add_report($urandom_range(1) ? HDR_B : HDR_A, pick_raw(cal_x_min, cal_x_span),
                   pick_raw(cal_y_min, cal_y_span));
        added += 5;
      end else if (sel < 85) begin
        n = $urandom_range(1, 3);
        repeat (n) add_tick();
        added += n;
      end else if (sel < 95) begin
        add_byte(8'($urandom));
        added += 1;
      end else begin
        add_byte($urandom_range(1) ? HDR_B : HDR_A);
        n = $urandom_range(1, 3);
        repeat (n) add_byte(8'($urandom));
        added += n + 1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part runs on the reset calibration.
    add_tick();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h22);
    add_byte(8'h1F);
    add_report(HDR_A, 16'h0000, 16'h0000);
    add_report(HDR_B, 16'hFFFF, 16'hFFFF);
    add_report(HDR_A, 16'd55, 16'd234);
    add_report(HDR_B, 16'h2120, 16'h2021);
    add_tick();
    add_tick();
    add_tick();
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      fill_random_phase();
      wait_drained();
    end

    if (errors == 0 && expected_events.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
